// ===== design/ppsd_pkg.sv =====
// ppsd_pkg: shared widths, constants and control types for the polytope distance block
// no dependencies

package ppsd_pkg;

  localparam int QW          = 32;
  localparam int JW          = 3;
  localparam int PROD_W      = 64;
  localparam int DOT_W       = 53;
  localparam int SQ_W        = 62;
  localparam int ROOT_W      = 31;
  localparam int MAG_W       = 52;
  localparam int DVD_W       = 66;
  localparam int BEST_W      = 68;
  localparam int STEP_W      = 7;
  localparam int SQRT_STEPS  = 31;
  localparam int DIV_STEPS   = 66;
  localparam int DEF_MAX_FACETS = 256;
  localparam int DEF_MAX_DIM    = 6;
  localparam int CFG_AW      = 3;

  localparam logic [BEST_W-1:0] CAP_Q16  = BEST_W'(100 * 65536);
  localparam logic [SQ_W-1:0]   SQRT_TOP = SQ_W'(1) << 60;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_DIMENSION   = 1'b0;
  localparam logic REG_FACET_COUNT = 1'b1;

  typedef struct packed {
    logic          point_ld;
    logic          acc_clr;
    logic          mul_n;
    logic          acc_dot;
    logic          acc_sq;
    logic          sqrt_init;
    logic          sqrt_step;
    logic          div_init;
    logic          div_step;
    logic          best_upd;
    logic [JW-1:0] j;
  } ppsd_cmd_t;

  typedef struct packed {
    logic root_zero;
  } ppsd_sts_t;

endpackage

// ===== design/ppsd_ram.sv =====
// ppsd_ram: generic single write port, single read port ram with registered read
// no dependencies

module ppsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ppsd_dp.sv =====
// ppsd_dp: facet stores, multiply-accumulate, iterative root and divider, minimum tracking
// depends on ppsd_pkg and ppsd_ram

module ppsd_dp
  import ppsd_pkg::*;
#(
  parameter int MAX_FACETS = DEF_MAX_FACETS,
  parameter int MAX_DIM    = DEF_MAX_DIM
) (
  input  logic                          clk,
  input  logic                          load_we,
  input  logic [$clog2(MAX_FACETS)-1:0] load_addr,
  input  logic [MAX_DIM*QW-1:0]         in_values,
  input  logic signed [QW-1:0]          in_offset,
  input  logic [$clog2(MAX_FACETS)-1:0] rd_addr,
  input  ppsd_cmd_t                     cmd,
  output ppsd_sts_t                     sts,
  output logic signed [QW-1:0]          min_distance
);

  logic [MAX_DIM*QW-1:0]     nrm_rd;
  logic [QW-1:0]             off_rd;
  logic signed [QW-1:0]      p_r [MAX_DIM];
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [DOT_W-1:0]   dot_r;
  logic [SQ_W-1:0]           sq_r;
  logic [SQ_W-1:0]           x_r, res_r, bit_r;
  logic                      neg_r;
  logic [ROOT_W-1:0]         rem_r;
  logic [DVD_W-1:0]          dvd_r, q_r;
  logic signed [BEST_W-1:0]  best_r;

  logic signed [QW-1:0]      n_j, a_j;
  logic signed [DOT_W-1:0]   num;
  logic [DOT_W-1:0]          mag_full;
  logic [SQ_W-1:0]           trial;
  logic [ROOT_W:0]           rem_sh;
  logic [ROOT_W:0]           root_ext;
  logic signed [BEST_W-1:0]  d;
  logic signed [BEST_W-1:0]  sat_lo;

  ppsd_ram #(.WIDTH(MAX_DIM*QW), .DEPTH(MAX_FACETS)) u_nrm (
    .clk(clk), .we(load_we), .waddr(load_addr), .wdata(in_values),
    .raddr(rd_addr), .rdata(nrm_rd)
  );

  ppsd_ram #(.WIDTH(QW), .DEPTH(MAX_FACETS)) u_off (
    .clk(clk), .we(load_we), .waddr(load_addr), .wdata(in_offset),
    .raddr(rd_addr), .rdata(off_rd)
  );

  always_comb begin
    n_j      = nrm_rd[cmd.j*QW +: QW];
    a_j      = cmd.mul_n ? n_j : p_r[cmd.j];
    num      = -(dot_r + DOT_W'(signed'(off_rd)));
    mag_full = num[DOT_W-1] ? DOT_W'(-num) : DOT_W'(num);
    trial    = res_r + bit_r;
    root_ext = {1'b0, res_r[ROOT_W-1:0]};
    rem_sh   = {rem_r, dvd_r[DVD_W-1]};
    d        = neg_r ? -BEST_W'(q_r) : BEST_W'(q_r);
    sat_lo   = -(BEST_W'(64'sd2147483648));
  end

  assign sts.root_zero = (res_r == '0);
  assign min_distance  = (best_r < sat_lo) ? {1'b1, {(QW-1){1'b0}}} : best_r[QW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.point_ld) begin
      for (int k = 0; k < MAX_DIM; k++) begin
        p_r[k] <= in_values[k*QW +: QW];
      end
      best_r <= CAP_Q16;
    end
    prod_r <= a_j * n_j;
    if (cmd.acc_clr) begin
      dot_r <= '0;
      sq_r  <= '0;
    end else begin
      if (cmd.acc_dot) begin
        dot_r <= dot_r + DOT_W'(signed'(prod_r[PROD_W-1:16]));
      end
      if (cmd.acc_sq) begin
        sq_r <= sq_r + SQ_W'(prod_r[PROD_W-1:4]);
      end
    end
    if (cmd.sqrt_init) begin
      x_r   <= sq_r;
      res_r <= '0;
      bit_r <= SQRT_TOP;
      neg_r <= num[DOT_W-1];
      dvd_r <= {mag_full[MAG_W-1:0], 14'd0};
    end else if (cmd.sqrt_step) begin
      if (x_r >= trial) begin
        x_r   <= x_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_r << 1;
      if (rem_sh >= root_ext) begin
        rem_r <= ROOT_W'(rem_sh - root_ext);
        q_r   <= {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[ROOT_W-1:0];
        q_r   <= {q_r[DVD_W-2:0], 1'b0};
      end
    end
    if (cmd.best_upd && (d < best_r)) begin
      best_r <= d;
    end
  end

endmodule

// ===== design/ppsd_ctrl.sv =====
// ppsd_ctrl: sequencer that walks the facets of a query through the datapath
// depends on ppsd_pkg

module ppsd_ctrl
  import ppsd_pkg::*;
#(
  parameter int MAX_FACETS = DEF_MAX_FACETS,
  parameter int MAX_DIM    = DEF_MAX_DIM
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          query_go,
  input  logic [2:0]                    dimension,
  input  logic [8:0]                    facet_count,
  input  ppsd_sts_t                     sts,
  output ppsd_cmd_t                     cmd,
  output logic [$clog2(MAX_FACETS)-1:0] rd_addr,
  output logic                          busy,
  output logic                          done
);

  localparam int AW   = $clog2(MAX_FACETS);
  localparam int CW   = $clog2(MAX_FACETS + 1);
  localparam int CMPW = (CW > 9) ? CW : 9;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_WAIT, S_MULP, S_MULN, S_FLUSH, S_SQRT_INIT, S_SQRT,
    S_DIV_INIT, S_DIV, S_UPD, S_NEXT, S_DONE
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       i_r;
  logic [JW-1:0]       j_r;
  logic [STEP_W-1:0]   step_r;
  logic [CMPW-1:0]     cnt_ext;
  logic [CW-1:0]       cnt;
  logic [JW-1:0]       dim;

  always_comb begin
    cnt_ext = (CMPW'(facet_count) > CMPW'(MAX_FACETS)) ? CMPW'(MAX_FACETS)
                                                       : CMPW'(facet_count);
    cnt     = cnt_ext[CW-1:0];
    dim     = (dimension > JW'(MAX_DIM)) ? JW'(MAX_DIM) : dimension;
  end

  assign rd_addr = i_r[AW-1:0];
  assign busy    = (state_r != S_IDLE);
  assign done    = (state_r == S_DONE);

  always_comb begin
    cmd           = '0;
    cmd.j         = j_r;
    cmd.point_ld  = query_go;
    cmd.acc_clr   = (state_r == S_WAIT);
    cmd.mul_n     = (state_r == S_MULN);
    cmd.acc_dot   = (state_r == S_MULN);
    cmd.acc_sq    = ((state_r == S_MULP) && (j_r != '0)) || (state_r == S_FLUSH);
    cmd.sqrt_init = (state_r == S_SQRT_INIT);
    cmd.sqrt_step = (state_r == S_SQRT);
    cmd.div_init  = (state_r == S_DIV_INIT);
    cmd.div_step  = (state_r == S_DIV);
    cmd.best_upd  = (state_r == S_UPD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          i_r <= '0;
          if (query_go) begin
            state_r <= (cnt == '0) ? S_DONE : S_READ;
          end
        end
        S_READ: state_r <= S_WAIT;
        S_WAIT: begin
          j_r     <= '0;
          state_r <= (dim == '0) ? S_SQRT_INIT : S_MULP;
        end
        S_MULP: state_r <= S_MULN;
        S_MULN: begin
          if (j_r + JW'(1) < dim) begin
            j_r     <= j_r + JW'(1);
            state_r <= S_MULP;
          end else begin
            state_r <= S_FLUSH;
          end
        end
        S_FLUSH: state_r <= S_SQRT_INIT;
        S_SQRT_INIT: begin
          step_r  <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
            state_r <= S_DIV_INIT;
          end
        end
        S_DIV_INIT: begin
          step_r  <= '0;
          state_r <= sts.root_zero ? S_NEXT : S_DIV;
        end
        S_DIV: begin
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(DIV_STEPS - 1)) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: state_r <= S_NEXT;
        S_NEXT: begin
          if (i_r + CW'(1) == cnt) begin
            state_r <= S_DONE;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_READ;
          end
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/point_polytope_min_signed_distance.sv =====
// point_polytope_min_signed_distance: top level with config registers and command port
// depends on ppsd_pkg, ppsd_ctrl and ppsd_dp
//
// usage: a word is taken at a rising edge with start high and busy low.
// in_command load writes one facet (normal plus offset) into the facet tables
// in that same edge; busy stays low and no result follows.
// in_command query latches the point and walks facet_count facets (clamped to
// MAX_FACETS), one at a time through a shared 32x32 multiplier, a root that
// settles one bit per cycle and a 1-bit-per-cycle divider; busy is high
// throughout.
// a facet whose root is zero skips the divider and leaves the minimum as it
// was; no new word is taken until busy falls again after the walk.
// the result appears on out_min_distance for one cycle with out_strobe high;
// the receiver cannot stall it.
// config registers over apb: dimension at 0, facet_count at 4; write only
// while idle. reset sets dimension 6 and facet_count 0; facet tables are not
// cleared and must be loaded before use.

module point_polytope_min_signed_distance
  import ppsd_pkg::*;
#(
  parameter int MAX_FACETS = DEF_MAX_FACETS,
  parameter int MAX_DIM    = DEF_MAX_DIM
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [7:0]         in_facet_index,
  input  logic signed [31:0] in_value_0,
  input  logic signed [31:0] in_value_1,
  input  logic signed [31:0] in_value_2,
  input  logic signed [31:0] in_value_3,
  input  logic signed [31:0] in_value_4,
  input  logic signed [31:0] in_value_5,
  input  logic signed [31:0] in_plane_offset,
  output logic               out_strobe,
  output logic signed [31:0] out_min_distance,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(MAX_FACETS);
  localparam int IW = (AW > 8) ? AW + 1 : 9;

  logic [2:0]            dimension_r;
  logic [8:0]            facet_count_r;
  logic [6*QW-1:0]       all_values;
  logic [MAX_DIM*QW-1:0] values;
  logic                  accept;
  logic                  query_go;
  logic                  load_we;
  logic [AW-1:0]         load_addr;
  logic [AW-1:0]         rd_addr;
  ppsd_cmd_t             cmd;
  ppsd_sts_t             sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FACET_COUNT) ? {23'd0, facet_count_r}
                                                : {29'd0, dimension_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dimension_r   <= 3'd6;
      facet_count_r <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_FACET_COUNT) begin
        facet_count_r <= pwdata[8:0];
      end else begin
        dimension_r <= pwdata[2:0];
      end
    end
  end

  assign all_values = {in_value_5, in_value_4, in_value_3, in_value_2, in_value_1, in_value_0};
  assign values     = all_values[MAX_DIM*QW-1:0];
  assign accept     = start && !busy;
  assign query_go   = accept && (in_command == CMD_QUERY);
  assign load_we    = accept && (in_command == CMD_LOAD) &&
                      (IW'(in_facet_index) < IW'(MAX_FACETS));
  assign load_addr  = AW'(in_facet_index);

  ppsd_ctrl #(.MAX_FACETS(MAX_FACETS), .MAX_DIM(MAX_DIM)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .query_go(query_go), .dimension(dimension_r),
    .facet_count(facet_count_r), .sts(sts), .cmd(cmd), .rd_addr(rd_addr),
    .busy(busy), .done(out_strobe)
  );

  ppsd_dp #(.MAX_FACETS(MAX_FACETS), .MAX_DIM(MAX_DIM)) u_dp (
    .clk(clk), .load_we(load_we), .load_addr(load_addr), .in_values(values),
    .in_offset(in_plane_offset), .rd_addr(rd_addr), .cmd(cmd), .sts(sts),
    .min_distance(out_min_distance)
  );

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for point_polytope_min_signed_distance
// depends on ppsd_pkg and the point_polytope_min_signed_distance rtl
// facet loads update the model; queries checked against an in-bench predictor

module tb;
  import ppsd_pkg::*;

  typedef struct {
    logic        cmd;
    logic [7:0]  idx;
    logic [31:0] v0, v1, v2, v3, v4, v5;
    logic [31:0] off;
    bit          chk;
    logic [31:0] md;
  } drow_t;

  localparam logic [31:0] CAP_MD = 32'h0064_0000;
  localparam logic [31:0] QMIN   = 32'h8000_0000;
  localparam logic [31:0] QMAX   = 32'h7fff_ffff;

  logic clk, rst_n, start, busy, out_strobe, pready;
  logic in_command;
  logic [7:0] in_facet_index;
  logic signed [31:0] in_value_0, in_value_1, in_value_2, in_value_3, in_value_4, in_value_5;
  logic signed [31:0] in_plane_offset, out_min_distance;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  point_polytope_min_signed_distance i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_facet_index(in_facet_index),
    .in_value_0(in_value_0), .in_value_1(in_value_1), .in_value_2(in_value_2),
    .in_value_3(in_value_3), .in_value_4(in_value_4), .in_value_5(in_value_5),
    .in_plane_offset(in_plane_offset), .out_strobe(out_strobe),
    .out_min_distance(out_min_distance), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // facet table and register shadow
  longint     facet_n [256][6];
  longint     facet_off [256];
  logic [2:0] dim_reg;
  logic [8:0] count_reg;

  logic [31:0] dist_q [$];
  logic [31:0] got_md;
  int          errors;
  int          n_words;

  // current word
  drow_t w;
  drow_t dir_tab [];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("point_polytope_min_signed_distance test failed");
    $finish;
  end

  function automatic longint unsigned isqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] min_distance(input longint pt [6]);
    longint best, dot, num, d, nj;
    longint unsigned sq, root, mag, q;
    int dim, cnt;
    best = 100 * 65536;
    dim = (dim_reg > 6) ? 6 : dim_reg;
    cnt = (count_reg > 256) ? 256 : count_reg;
    for (int i = 0; i < cnt; i++) begin
      dot = 0;
      sq = 0;
      for (int j = 0; j < dim; j++) begin
        nj = facet_n[i][j];
        dot += (pt[j] * nj) >>> 16;
        sq += longint'(nj * nj) >> 4;
      end
      root = isqrt(sq);
      if (root != 0) begin
        num = -(dot + facet_off[i]);
        mag = (num < 0) ? -num : num;
        q = (mag << 14) / root;
        d = (num < 0) ? -longint'(q) : longint'(q);
        if (d < best) best = d;
      end
    end
    if (best < -64'sh8000_0000) best = -64'sh8000_0000;
    return best[31:0];
  endfunction

  function automatic logic [31:0] rnd_q();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2, 3: return 32'($urandom_range(0, 32'h40000)) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (dist_q.size() == 0) begin
        $error("min_distance: no word expected, got %h", out_min_distance);
        errors++;
      end else begin
        got_md = dist_q.pop_front();
        if (out_min_distance !== got_md) begin
          $error("min_distance: expected %h, got %h", got_md, out_min_distance);
          errors++;
        end
      end
    end
  end

  task automatic issue();
    longint pt [6];
    start <= 1'b1;
    in_command <= w.cmd;
    in_facet_index <= w.idx;
    in_value_0 <= w.v0;
    in_value_1 <= w.v1;
    in_value_2 <= w.v2;
    in_value_3 <= w.v3;
    in_value_4 <= w.v4;
    in_value_5 <= w.v5;
    in_plane_offset <= w.off;
    @(posedge clk);
    while (busy) @(posedge clk);
    pt[0] = signed'(w.v0); pt[1] = signed'(w.v1); pt[2] = signed'(w.v2);
    pt[3] = signed'(w.v3); pt[4] = signed'(w.v4); pt[5] = signed'(w.v5);
    n_words++;
    if (w.cmd == CMD_LOAD) begin
      for (int j = 0; j < 6; j++) facet_n[w.idx][j] = pt[j];
      facet_off[w.idx] = signed'(w.off);
    end else begin
      dist_q.push_back(w.chk ? w.md : min_distance(pt));
    end
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (dist_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic sel, input logic [31:0] val);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_DIMENSION) dim_reg = val[2:0];
    else count_reg = val[8:0];
  endtask

  task automatic rand_word(input bit query, input bit near);
    w.cmd = query ? CMD_QUERY : CMD_LOAD;
    w.idx = near ? 8'($urandom_range(0, 15)) : 8'($urandom);
    w.v0 = rnd_q(); w.v1 = rnd_q(); w.v2 = rnd_q();
    w.v3 = rnd_q(); w.v4 = rnd_q(); w.v5 = rnd_q();
    w.off = rnd_q();
    w.chk = 1'b0;
    w.md = '0;
  endtask

  initial begin
    int cnt, len, nq;
    errors = 0;
    n_words = 0;
    dim_reg = 3'd6;
    count_reg = 9'd0;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_LOAD;
    in_facet_index = '0;
    in_value_0 = '0; in_value_1 = '0; in_value_2 = '0;
    in_value_3 = '0; in_value_4 = '0; in_value_5 = '0;
    in_plane_offset = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;

    dir_tab = '{
      '{CMD_LOAD,  8'd0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0},
      '{CMD_QUERY, 8'd0, 32'h10000, 0, 0, 0, 0, 0, 0, 1'b1, CAP_MD},
      '{CMD_LOAD,  8'd0, 32'h10000, 0, 0, 0, 0, 0, 0, 1'b0, 0},
      '{CMD_QUERY, 8'd0, 32'h20000, 0, 0, 0, 0, 0, 0, 1'b1, 32'hfffe_0000},
      '{CMD_LOAD,  8'd0, 32'h40, 0, 0, 0, 0, 0, 32'h7fff_ffff, 1'b0, 0},
      '{CMD_QUERY, 8'd0, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 1'b1, 32'h8000_0000},
      '{CMD_LOAD,  8'd0, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 1'b0, 0},
      '{CMD_QUERY, 8'hff, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, 1'b0, 0},
      '{CMD_QUERY, 8'd0, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 1'b0, 0},
      '{CMD_LOAD,  8'd0, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, 1'b0, 0},
      '{CMD_QUERY, 8'd0, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 0, 1'b0, 0},
      '{CMD_QUERY, 8'd0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0},
      '{CMD_LOAD,  8'd0, 1, 1, 1, 0, 0, 0, 32'h10000, 1'b0, 0},
      '{CMD_QUERY, 8'd0, 32'h10000, 32'h10000, 0, 0, 0, 0, 0, 1'b1, CAP_MD},
      '{CMD_LOAD,  8'hff, 32'h10000, 32'hffff_0000, 0, 0, 0, 0, 32'h8000, 1'b0, 0}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nothing loaded and no facets walked: the cap comes back
    w = '{CMD_QUERY, 8'd0, 0, 0, 0, 0, 0, 0, 0, 1'b1, CAP_MD};
    issue();

    // every table entry written once before any query walks it
    for (int i = 0; i < 256; i++) begin
      rand_word(1'b0, 1'b0);
      w.idx = i[7:0];
      issue();
    end
    reg_write(REG_FACET_COUNT, 32'd1);
    foreach (dir_tab[k]) begin
      w = dir_tab[k];
      issue();
    end

    for (int ph = 0; n_words < 1150; ph++) begin
      case (ph)
        0: reg_write(REG_DIMENSION, 32'd0);
        1: reg_write(REG_DIMENSION, 32'd7);
        default: reg_write(REG_DIMENSION, 32'($urandom_range(0, 7)));
      endcase
      cnt = $urandom_range(1, 8);
      len = 40;
      if (ph == 4 || ph == 9) begin
        cnt = (ph == 4) ? 256 : 511;
        len = 6;
      end else if (ph % 7 == 5) begin
        cnt = 0;
      end else if (ph % 5 == 3) begin
        cnt = $urandom_range(9, 40);
        len = 12;
      end
      reg_write(REG_FACET_COUNT, 32'(cnt));
      nq = 0;
      for (int k = 0; k < len; k++) begin
        rand_word($urandom_range(0, 1) == 1, $urandom_range(0, 3) != 0);
        if (len == 6 && w.cmd == CMD_QUERY && nq == 2) w.cmd = CMD_LOAD;
        if (w.cmd == CMD_QUERY) nq++;
        issue();
        if (k == len / 2 && ph % 3 == 0) begin
          drain();
        end else if (ph % 4 != 1 && $urandom_range(0, 3) == 0) begin
          hold_off($urandom_range(1, 25));
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("point_polytope_min_signed_distance test passed");
    end else begin
      $display("point_polytope_min_signed_distance test failed");
    end
    $finish;
  end

endmodule
